// ----- design/frc_pkg.sv -----
// ----------------------------------------------------------------------------
// frc_pkg: shared types and constants of the framed packet receiver
// Holds the sync bytes, payload limits, status codes, the CRC-16 byte step
// and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package frc_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
    localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);

    localparam logic [7:0]  SYNC_A   = 8'h26;
    localparam logic [7:0]  SYNC_B   = 8'h56;
    localparam logic [7:0]  SYNC_C   = 8'h7E;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [7:0]  VERSION_RESET = 8'h01;

    typedef enum logic [2:0] {
        STATUS_OK      = 3'd0,
        STATUS_CRC     = 3'd1,
        STATUS_VERSION = 3'd2,
        STATUS_LENGTH  = 3'd3,
        STATUS_SYNC    = 3'd4
    } frc_status_t;

    typedef struct packed {
        logic        seq_lo_ld;
        logic        seq_hi_ld;
        logic        crc_start;
        logic        crc_feed;
        logic        kind_ld;
        logic        len_ld;
        logic        data_wr;
        logic        crc_lo_ld;
        logic        good_commit;
        logic        emit_start;
        logic        emit_load;
        logic        out_err;
        logic        out_empty;
        frc_status_t err_code;
    } frc_cmd_t;

    typedef struct packed {
        logic sync_a;
        logic sync_b;
        logic sync_c;
        logic ver_ok;
        logic len_bad;
        logic len_byte_zero;
        logic count_done;
        logic crc_ok;
        logic len_reg_zero;
        logic rd_ok;
        logic emit_last;
        logic out_free;
    } frc_stat_t;

    // One byte through CRC-16/CCITT, most significant bit first.
    function automatic logic [15:0] crc_step(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- design/frc_ctrl.sv -----
// ----------------------------------------------------------------------------
// frc_ctrl: packet parsing controller
// Walks the frame layout one accepted byte at a time and then sequences the
// payload burst, issuing commands to the datapath.
// ----------------------------------------------------------------------------
module frc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  frc_pkg::frc_stat_t stat,
    output frc_pkg::frc_cmd_t  cmd
);
    import frc_pkg::*;

    typedef enum logic [11:0] {
        ST_SYNC1 = 12'b0000_0000_0001,
        ST_SYNC2 = 12'b0000_0000_0010,
        ST_SYNC3 = 12'b0000_0000_0100,
        ST_SEQLO = 12'b0000_0000_1000,
        ST_SEQHI = 12'b0000_0001_0000,
        ST_VER   = 12'b0000_0010_0000,
        ST_KIND  = 12'b0000_0100_0000,
        ST_LEN   = 12'b0000_1000_0000,
        ST_DATA  = 12'b0001_0000_0000,
        ST_CRCLO = 12'b0010_0000_0000,
        ST_CRCHI = 12'b0100_0000_0000,
        ST_EMIT  = 12'b1000_0000_0000
    } frc_state_t;

    frc_state_t state_reg, state_next;
    logic       accept;

    // Bytes are taken only while parsing and only when the output register
    // can hold any status the byte might cause.
    assign s_tready = (state_reg != ST_EMIT) && stat.out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.err_code = STATUS_OK;
        case (state_reg)
            ST_SYNC1: begin
                if (accept && stat.sync_a) begin
                    state_next = ST_SYNC2;
                end
            end
            ST_SYNC2: begin
                if (accept) begin
                    if (stat.sync_b) begin
                        state_next = ST_SYNC3;
                    end else if (!stat.sync_a) begin
                        cmd.out_err  = 1'b1;
                        cmd.err_code = STATUS_SYNC;
                        state_next   = ST_SYNC1;
                    end
                end
            end
            ST_SYNC3: begin
                if (accept) begin
                    if (stat.sync_c) begin
                        state_next = ST_SEQLO;
                    end else begin
                        cmd.out_err  = 1'b1;
                        cmd.err_code = STATUS_SYNC;
                        state_next   = ST_SYNC1;
                    end
                end
            end
            ST_SEQLO: begin
                if (accept) begin
                    cmd.seq_lo_ld = 1'b1;
                    cmd.crc_start = 1'b1;
                    state_next    = ST_SEQHI;
                end
            end
            ST_SEQHI: begin
                if (accept) begin
                    cmd.seq_hi_ld = 1'b1;
                    cmd.crc_feed  = 1'b1;
                    state_next    = ST_VER;
                end
            end
            ST_VER: begin
                if (accept) begin
                    cmd.crc_feed = 1'b1;
                    if (stat.ver_ok) begin
                        state_next = ST_KIND;
                    end else begin
                        cmd.out_err  = 1'b1;
                        cmd.err_code = STATUS_VERSION;
                        state_next   = ST_SYNC1;
                    end
                end
            end
            ST_KIND: begin
                if (accept) begin
                    cmd.kind_ld  = 1'b1;
                    cmd.crc_feed = 1'b1;
                    state_next   = ST_LEN;
                end
            end
            ST_LEN: begin
                if (accept) begin
                    cmd.crc_feed = 1'b1;
                    if (stat.len_bad) begin
                        cmd.out_err  = 1'b1;
                        cmd.err_code = STATUS_LENGTH;
                        state_next   = ST_SYNC1;
                    end else begin
                        cmd.len_ld = 1'b1;
                        state_next = stat.len_byte_zero ? ST_CRCLO : ST_DATA;
                    end
                end
            end
            ST_DATA: begin
                if (accept) begin
                    cmd.crc_feed = 1'b1;
                    cmd.data_wr  = 1'b1;
                    if (stat.count_done) begin
                        state_next = ST_CRCLO;
                    end
                end
            end
            ST_CRCLO: begin
                if (accept) begin
                    cmd.crc_lo_ld = 1'b1;
                    state_next    = ST_CRCHI;
                end
            end
            ST_CRCHI: begin
                if (accept) begin
                    if (!stat.crc_ok) begin
                        cmd.out_err  = 1'b1;
                        cmd.err_code = STATUS_CRC;
                        state_next   = ST_SYNC1;
                    end else begin
                        cmd.good_commit = 1'b1;
                        if (stat.len_reg_zero) begin
                            cmd.out_empty = 1'b1;
                            state_next    = ST_SYNC1;
                        end else begin
                            cmd.emit_start = 1'b1;
                            state_next     = ST_EMIT;
                        end
                    end
                end
            end
            ST_EMIT: begin
                if (stat.rd_ok && stat.out_free) begin
                    cmd.emit_load = 1'b1;
                    if (stat.emit_last) begin
                        state_next = ST_SYNC1;
                    end
                end
            end
            default: begin
                state_next = ST_SYNC1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SYNC1;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- design/frc_datapath.sv -----
// ----------------------------------------------------------------------------
// frc_datapath: header registers, CRC, payload store and output register
// Captures frame fields on command, runs the CRC, buffers the payload and
// builds each result beat in a registered output stage.
// ----------------------------------------------------------------------------
module frc_datapath (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [7:0]             rx_byte,
    input  logic                   cfg_we,
    input  logic [7:0]             cfg_wdata,
    input  logic                   m_tready,
    input  frc_pkg::frc_cmd_t      cmd,
    output frc_pkg::frc_stat_t     stat,
    output logic                   out_valid,
    output frc_pkg::frc_status_t   out_status,
    output logic                   out_gap,
    output logic [7:0]             out_kind,
    output logic [15:0]            out_seq,
    output logic [5:0]             out_len,
    output logic [4:0]             out_idx,
    output logic [7:0]             out_byte,
    output logic                   out_pv,
    output logic                   out_last
);
    import frc_pkg::*;

    logic [7:0]        version_reg, version_next;
    logic [15:0]       seq_reg, seq_next;
    logic [15:0]       crc_reg, crc_next;
    logic [7:0]        crc_lo_reg, crc_lo_next;
    logic [7:0]        kind_reg, kind_next;
    logic [LEN_W-1:0]  length_reg, length_next;
    logic [LEN_W-1:0]  count_reg, count_next;
    logic [15:0]       prev_seq_reg, prev_seq_next;
    logic              seen_reg, seen_next;
    logic              gap_reg, gap_next;
    logic [ADDR_W-1:0] emit_idx_reg, emit_idx_next;
    logic              rd_ok_reg, rd_ok_next;
    logic [7:0]        rdata_reg;
    logic [7:0]        payload_mem [MAX_PAYLOAD];

    logic              out_valid_reg, out_valid_next;
    frc_status_t       out_status_reg, out_status_next;
    logic              out_gap_reg, out_gap_next;
    logic [7:0]        out_kind_reg, out_kind_next;
    logic [15:0]       out_seq_reg, out_seq_next;
    logic [5:0]        out_len_reg, out_len_next;
    logic [4:0]        out_idx_reg, out_idx_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic              out_pv_reg, out_pv_next;
    logic              out_last_reg, out_last_next;

    logic [LEN_W:0]    count_inc;
    logic              gap_now;

    assign count_inc = {1'b0, count_reg} + (LEN_W + 1)'(1);
    assign gap_now   = seen_reg && (seq_reg != prev_seq_reg + 16'd1);

    always_comb begin
        stat.sync_a        = (rx_byte == SYNC_A);
        stat.sync_b        = (rx_byte == SYNC_B);
        stat.sync_c        = (rx_byte == SYNC_C);
        stat.ver_ok        = (rx_byte == version_reg);
        stat.len_bad       = (rx_byte > 8'(MAX_PAYLOAD));
        stat.len_byte_zero = (rx_byte == 8'd0);
        stat.count_done    = (count_inc >= {1'b0, length_reg});
        stat.crc_ok        = ({rx_byte, crc_lo_reg} == crc_reg);
        stat.len_reg_zero  = (length_reg == '0);
        stat.rd_ok         = rd_ok_reg;
        stat.emit_last     = (LEN_W'(emit_idx_reg) == length_reg - LEN_W'(1));
        stat.out_free      = !out_valid_reg || m_tready;
    end

    // Frame field capture and CRC.
    always_comb begin
        version_next  = cfg_we ? cfg_wdata : version_reg;
        seq_next      = seq_reg;
        crc_next      = crc_reg;
        crc_lo_next   = cmd.crc_lo_ld ? rx_byte : crc_lo_reg;
        kind_next     = cmd.kind_ld ? rx_byte : kind_reg;
        length_next   = cmd.len_ld ? LEN_W'(rx_byte) : length_reg;
        count_next    = count_reg;
        prev_seq_next = prev_seq_reg;
        seen_next     = seen_reg;
        gap_next      = gap_reg;
        if (cmd.seq_lo_ld) begin
            seq_next = {8'h00, rx_byte};
        end
        if (cmd.seq_hi_ld) begin
            seq_next = {rx_byte, seq_reg[7:0]};
        end
        if (cmd.crc_start) begin
            crc_next = crc_step(CRC_INIT, rx_byte);
        end else if (cmd.crc_feed) begin
            crc_next = crc_step(crc_reg, rx_byte);
        end
        if (cmd.len_ld) begin
            count_next = '0;
        end else if (cmd.data_wr) begin
            count_next = count_inc[LEN_W-1:0];
        end
        if (cmd.good_commit) begin
            gap_next      = gap_now;
            prev_seq_next = seq_reg;
            seen_next     = 1'b1;
        end
    end

    // Burst read side: the store is read every cycle at the current index;
    // rd_ok says the read data already belongs to that index.
    always_comb begin
        emit_idx_next = emit_idx_reg;
        rd_ok_next    = 1'b1;
        if (cmd.emit_start) begin
            emit_idx_next = '0;
            rd_ok_next    = 1'b0;
        end else if (cmd.emit_load) begin
            emit_idx_next = emit_idx_reg + ADDR_W'(1);
            rd_ok_next    = 1'b0;
        end
    end

    // Output register.
    always_comb begin
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_gap_next    = out_gap_reg;
        out_kind_next   = out_kind_reg;
        out_seq_next    = out_seq_reg;
        out_len_next    = out_len_reg;
        out_idx_next    = out_idx_reg;
        out_byte_next   = out_byte_reg;
        out_pv_next     = out_pv_reg;
        out_last_next   = out_last_reg;
        if (cmd.out_err) begin
            out_valid_next  = 1'b1;
            out_status_next = cmd.err_code;
            out_gap_next    = 1'b0;
            out_kind_next   = '0;
            out_seq_next    = '0;
            out_len_next    = '0;
            out_idx_next    = '0;
            out_byte_next   = '0;
            out_pv_next     = 1'b0;
            out_last_next   = 1'b1;
        end else if (cmd.out_empty) begin
            out_valid_next  = 1'b1;
            out_status_next = STATUS_OK;
            out_gap_next    = gap_now;
            out_kind_next   = kind_reg;
            out_seq_next    = seq_reg;
            out_len_next    = '0;
            out_idx_next    = '0;
            out_byte_next   = '0;
            out_pv_next     = 1'b0;
            out_last_next   = 1'b1;
        end else if (cmd.emit_load) begin
            out_valid_next  = 1'b1;
            out_status_next = STATUS_OK;
            out_gap_next    = gap_reg;
            out_kind_next   = kind_reg;
            out_seq_next    = seq_reg;
            out_len_next    = 6'(length_reg);
            out_idx_next    = 5'(emit_idx_reg);
            out_byte_next   = rdata_reg;
            out_pv_next     = 1'b1;
            out_last_next   = stat.emit_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.data_wr) begin
            payload_mem[count_reg[ADDR_W-1:0]] <= rx_byte;
        end
        rdata_reg <= payload_mem[emit_idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            version_reg   <= VERSION_RESET;
            prev_seq_reg  <= '0;
            seen_reg      <= 1'b0;
            rd_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            version_reg   <= version_next;
            prev_seq_reg  <= prev_seq_next;
            seen_reg      <= seen_next;
            rd_ok_reg     <= rd_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        seq_reg        <= seq_next;
        crc_reg        <= crc_next;
        crc_lo_reg     <= crc_lo_next;
        kind_reg       <= kind_next;
        length_reg     <= length_next;
        count_reg      <= count_next;
        gap_reg        <= gap_next;
        emit_idx_reg   <= emit_idx_next;
        out_status_reg <= out_status_next;
        out_gap_reg    <= out_gap_next;
        out_kind_reg   <= out_kind_next;
        out_seq_reg    <= out_seq_next;
        out_len_reg    <= out_len_next;
        out_idx_reg    <= out_idx_next;
        out_byte_reg   <= out_byte_next;
        out_pv_reg     <= out_pv_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_gap    = out_gap_reg;
    assign out_kind   = out_kind_reg;
    assign out_seq    = out_seq_reg;
    assign out_len    = out_len_reg;
    assign out_idx    = out_idx_reg;
    assign out_byte   = out_byte_reg;
    assign out_pv     = out_pv_reg;
    assign out_last   = out_last_reg;

endmodule

// ----- design/framed_packet_receiver_crc16.sv -----
// ----------------------------------------------------------------------------
// framed_packet_receiver_crc16: sync-word packet deframer with CRC-16 check
// Finds frames in a received byte stream and delivers payload or status.
// ----------------------------------------------------------------------------
// Usage: received bytes enter on the slave channel, one byte per beat in
// s_tdata. A frame is the sync bytes 0x26 0x56 0x7E, a little-endian sequence
// number, a version byte, a type byte, a length byte, the payload and a
// little-endian CRC-16/CCITT. The version byte must match the value written
// through cfg_we and cfg_wdata, which is 1 after reset.
// Results leave on the master channel. A good frame gives one beat per
// payload byte with the header fields repeated and tlast on the final beat,
// or a single beat with payload_valid low for an empty frame. Each error
// gives one status beat with tlast set.
// Throughput: a byte is accepted every cycle while parsing and the output
// register is free. A status beat shows in the cycle after the byte that
// caused it. A payload burst waits on the registered read of the payload
// store, and each beat waits for a fresh read at its index before it is
// loaded; bytes are held off for the whole burst.
// When the receiver stalls, the output register holds its beat and s_tready
// stays low until that beat is taken. Reset returns the parser to hunting
// for the first sync byte and forgets the previous sequence number.
// ----------------------------------------------------------------------------
module framed_packet_receiver_crc16 (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,  // protocol_version
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] sequence_gap, [8:1] packet_kind, [24:9] sequence_number,
    // [30:25] payload_length, [35:31] byte_index, [43:36] payload_byte,
    // [47:44] zero
    output logic [47:0] m_tdata,
    output logic [3:0]  m_tuser,    // [2:0] status, [3] payload_valid
    output logic        m_tlast
);
    import frc_pkg::*;

    frc_cmd_t    cmd;
    frc_stat_t   stat;
    frc_status_t out_status;
    logic        out_gap;
    logic [7:0]  out_kind;
    logic [15:0] out_seq;
    logic [5:0]  out_len;
    logic [4:0]  out_idx;
    logic [7:0]  out_byte;
    logic        out_pv;

    // The controller owns the frame layout; the datapath owns every stored
    // field, the CRC and the output register.
    frc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    frc_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rx_byte    (s_tdata),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .m_tready   (m_tready),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (m_tvalid),
        .out_status (out_status),
        .out_gap    (out_gap),
        .out_kind   (out_kind),
        .out_seq    (out_seq),
        .out_len    (out_len),
        .out_idx    (out_idx),
        .out_byte   (out_byte),
        .out_pv     (out_pv),
        .out_last   (m_tlast)
    );

    // Result fields are packed from the lowest bit up, padded to six bytes.
    assign m_tdata = {4'h0, out_byte, out_idx, out_len, out_seq, out_kind, out_gap};
    assign m_tuser = {out_pv, out_status};

`ifndef NO_ASSERTIONS
    // No byte may be taken while a result still waits in the output register.
    a_no_accept_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("byte accepted while output register is full");

    // Payload beats only ever belong to a good frame.
    a_payload_is_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[3]) |-> (m_tuser[2:0] == STATUS_OK))
        else $error("payload beat with error status");

    // Every error status is a run of one beat.
    a_error_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[2:0] != STATUS_OK)) |-> (m_tlast && !m_tuser[3]))
        else $error("error status without tlast");

    // Input is held off for the whole payload burst.
    a_burst_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[3] && !m_tlast) |-> !s_tready)
        else $error("byte accepted during payload burst");
`endif

endmodule

// ----- tb/tb_framed_packet_receiver_crc16.sv -----
// ----------------------------------------------------------------------------
// tb_framed_packet_receiver_crc16: self-checking bench for the packet deframer
// Feeds directed and randomised byte streams (good frames, corrupted frames,
// broken sync and line noise) under several protocol versions, predicts
// every result beat and compares it field by field with the block's output.
// ----------------------------------------------------------------------------
module tb_framed_packet_receiver_crc16;

    import frc_pkg::*;

    // Length of the deliberate receiver hold-off used to back the block up.
    localparam int HOLD_CYCLES = 400;

    // Parser position, tracked by the prediction alongside the block.
    typedef enum logic [3:0] {
        SEEK_A,
        SEEK_B,
        SEEK_C,
        GET_SEQ_LO,
        GET_SEQ_HI,
        GET_VERSION,
        GET_KIND,
        GET_LENGTH,
        GET_PAYLOAD,
        GET_CRC_LO,
        GET_CRC_HI
    } rx_phase_t;

    // One result beat with every field at the width the block gives it.
    typedef struct packed {
        frc_status_t status;
        logic        gap;
        logic [7:0]  kind;
        logic [15:0] seq;
        logic [5:0]  plen;
        logic [4:0]  idx;
        logic [7:0]  pbyte;
        logic        pvalid;
        logic        last;
    } deframe_beat_t;

    // The scoreboard holds its own copy of the parser state and the version
    // register. Every accepted byte is run through it, and the beats it
    // predicts wait in a queue until the block delivers them.
    class frame_scoreboard;
        logic [7:0]    version_reg;
        rx_phase_t     phase;
        logic [5:0]    count;
        logic [15:0]   seq;
        logic [15:0]   crc;
        logic [7:0]    crc_lo;
        logic [7:0]    kind;
        logic [5:0]    len;
        logic [7:0]    payload [MAX_PAYLOAD];
        logic [15:0]   prev_seq;
        bit            seen_good;
        deframe_beat_t pending [$];
        int            fails;
        int            beats_checked;
        int            good_frames;
        int            error_reports;

        function new();
            version_reg   = VERSION_RESET;
            phase         = SEEK_A;
            count         = '0;
            seq           = '0;
            crc           = CRC_INIT;
            crc_lo        = '0;
            kind          = '0;
            len           = '0;
            prev_seq      = '0;
            seen_good     = 1'b0;
            fails         = 0;
            beats_checked = 0;
            good_frames   = 0;
            error_reports = 0;
        endfunction

        // Bit-serial form of CRC-16/CCITT, most significant bit first.
        function logic [15:0] crc_advance(logic [15:0] c, logic [7:0] b);
            logic fb;
            for (int i = 7; i >= 0; i--) begin
                fb = c[15] ^ b[i];
                c  = {c[14:0], 1'b0};
                if (fb) begin
                    c = c ^ CRC_POLY;
                end
            end
            return c;
        endfunction

        function void push_status(frc_status_t code);
            deframe_beat_t beat;
            beat        = '0;
            beat.status = code;
            beat.last   = 1'b1;
            pending.push_back(beat);
            error_reports++;
        endfunction

        function void push_good();
            deframe_beat_t beat;
            logic [15:0]   follow;
            follow      = prev_seq + 16'd1;
            beat        = '0;
            beat.status = STATUS_OK;
            beat.gap    = seen_good && (seq != follow);
            beat.kind   = kind;
            beat.seq    = seq;
            seen_good   = 1'b1;
            prev_seq    = seq;
            good_frames++;
            if (len == 0) begin
                beat.last = 1'b1;
                pending.push_back(beat);
                return;
            end
            beat.plen   = len;
            beat.pvalid = 1'b1;
            for (int i = 0; i < len; i++) begin
                beat.idx   = 5'(i);
                beat.pbyte = payload[i];
                beat.last  = (i == len - 1);
                pending.push_back(beat);
            end
        endfunction

        function void note_byte(logic [7:0] b);
            case (phase)
                SEEK_A: begin
                    if (b == SYNC_A) begin
                        phase = SEEK_B;
                    end
                end
                SEEK_B: begin
                    if (b == SYNC_B) begin
                        phase = SEEK_C;
                    end else if (b != SYNC_A) begin
                        phase = SEEK_A;
                        push_status(STATUS_SYNC);
                    end
                end
                SEEK_C: begin
                    if (b == SYNC_C) begin
                        phase = GET_SEQ_LO;
                    end else begin
                        phase = SEEK_A;
                        push_status(STATUS_SYNC);
                    end
                end
                GET_SEQ_LO: begin
                    crc   = crc_advance(CRC_INIT, b);
                    seq   = {8'h00, b};
                    phase = GET_SEQ_HI;
                end
                GET_SEQ_HI: begin
                    crc       = crc_advance(crc, b);
                    seq[15:8] = b;
                    phase     = GET_VERSION;
                end
                GET_VERSION: begin
                    crc = crc_advance(crc, b);
                    if (b != version_reg) begin
                        phase = SEEK_A;
                        push_status(STATUS_VERSION);
                    end else begin
                        phase = GET_KIND;
                    end
                end
                GET_KIND: begin
                    crc   = crc_advance(crc, b);
                    kind  = b;
                    phase = GET_LENGTH;
                end
                GET_LENGTH: begin
                    crc = crc_advance(crc, b);
                    if (b > MAX_PAYLOAD) begin
                        phase = SEEK_A;
                        push_status(STATUS_LENGTH);
                    end else begin
                        len   = b[5:0];
                        count = '0;
                        phase = (b == 8'd0) ? GET_CRC_LO : GET_PAYLOAD;
                    end
                end
                GET_PAYLOAD: begin
                    crc = crc_advance(crc, b);
                    if (count < MAX_PAYLOAD) begin
                        payload[count] = b;
                    end
                    count = count + 6'd1;
                    if (count >= len) begin
                        phase = GET_CRC_LO;
                    end
                end
                GET_CRC_LO: begin
                    crc_lo = b;
                    phase  = GET_CRC_HI;
                end
                GET_CRC_HI: begin
                    phase = SEEK_A;
                    if ({b, crc_lo} != crc) begin
                        push_status(STATUS_CRC);
                    end else begin
                        push_good();
                    end
                end
                default: begin
                    phase = SEEK_A;
                end
            endcase
        endfunction

        // One line per mismatch, each one counted.
        task report(string msg);
            fails++;
            $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        task compare_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want) begin
                report($sformatf("%s is %0h, expected %0h", name, got, want));
            end
        endtask

        task check_beat(deframe_beat_t got);
            deframe_beat_t want;
            beats_checked++;
            if (pending.size() == 0) begin
                report($sformatf("beat with status %0d arrived with nothing expected",
                                 got.status));
                return;
            end
            want = pending.pop_front();
            compare_field("status", got.status, want.status);
            compare_field("sequence_gap", got.gap, want.gap);
            compare_field("packet_kind", got.kind, want.kind);
            compare_field("sequence_number", got.seq, want.seq);
            compare_field("payload_length", got.plen, want.plen);
            compare_field("byte_index", got.idx, want.idx);
            compare_field("payload_byte", got.pbyte, want.pbyte);
            compare_field("payload_valid", got.pvalid, want.pvalid);
            compare_field("last", got.last, want.last);
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    frame_scoreboard sb;

    // Bytes waiting to be offered, and the CRC built up while framing them.
    logic [7:0]  tx_bytes [$];
    logic [15:0] tx_crc;
    // Sequence number that the next in-order good frame would carry.
    logic [15:0] next_seq;
    // When clear, the sender offers bytes back to back with no gaps.
    bit          tx_pace;
    // Set by the stimulus to ask the receiver for one long hold-off.
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;
    int          bytes_sent = 0;
    int          long_holds = 0;
    int          versions_used = 1;

    always #4 aclk = ~aclk;

    framed_packet_receiver_crc16 DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // Result monitor. Outputs are sampled at the clock edge, before the
    // block's own registers move, so each accepted beat is seen exactly once.
    always @(posedge aclk) begin
        deframe_beat_t got;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            got.status = frc_status_t'(m_tuser[2:0]);
            got.pvalid = m_tuser[3];
            got.gap    = m_tdata[0];
            got.kind   = m_tdata[8:1];
            got.seq    = m_tdata[24:9];
            got.plen   = m_tdata[30:25];
            got.idx    = m_tdata[35:31];
            got.pbyte  = m_tdata[43:36];
            got.last   = m_tlast;
            sb.check_beat(got);
        end
    end

    // Receiver side. It alternates between runs of readiness and stalls of
    // mixed length, with the occasional long stretch of no stalling at all.
    // When the stimulus asks for it, it holds off for a long, counted
    // stretch so that the output register fills and the input backs up.
    initial begin : result_sink
        int span;
        int r;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                for (span = 0; span < HOLD_CYCLES; span++) begin
                    @(posedge aclk);
                end
                hold_req = 1'b0;
                long_holds++;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    m_tready <= 1'b1;
                    span = $urandom_range(1, 30);
                end else if (r < 55) begin
                    m_tready <= 1'b1;
                    span = $urandom_range(100, 200);
                end else if (r < 88) begin
                    m_tready <= 1'b0;
                    span = $urandom_range(1, 3);
                end else if (r < 96) begin
                    m_tready <= 1'b0;
                    span = $urandom_range(5, 15);
                end else begin
                    m_tready <= 1'b0;
                    span = $urandom_range(30, 60);
                end
                // A hold-off request cuts the current stretch short so that
                // it starts while the sender is still busy.
                for (int k = 0; k < span && !hold_req; k++) begin
                    @(posedge aclk);
                end
            end
        end
    end

    // Idle cycles before the next byte: mostly none or a few, now and then
    // a long pause so that gaps land in every parser phase.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!tx_pace || r < 75) begin
            return 0;
        end
        if (r < 96) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Offers every queued byte in turn. tvalid stays high from one byte to
    // the next when there is no gap, so it is never lowered and raised in
    // the same step. Each byte goes to the scoreboard once it is accepted.
    task automatic send_queued();
        logic [7:0] b;
        int         gap;
        while (tx_bytes.size() != 0) begin
            b   = tx_bytes.pop_front();
            gap = pick_gap();
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= b;
            @(posedge aclk);
            while (s_tready !== 1'b1) begin
                @(posedge aclk);
            end
            sb.note_byte(b);
            bytes_sent++;
        end
    endtask

    task automatic put_body(input logic [7:0] b);
        tx_bytes.push_back(b);
        tx_crc = sb.crc_advance(tx_crc, b);
    endtask

    // Queues one frame. A frame that the block will reject at the version or
    // length byte stops there, as the parser goes back to hunting anyway.
    // A corrupted frame has one bit of its CRC flipped.
    task automatic queue_frame(input logic [15:0] seq, input logic [7:0] ver,
                               input logic [7:0] kind, input logic [7:0] len,
                               input bit bad_crc);
        tx_bytes.push_back(SYNC_A);
        tx_bytes.push_back(SYNC_B);
        tx_bytes.push_back(SYNC_C);
        tx_crc = CRC_INIT;
        put_body(seq[7:0]);
        put_body(seq[15:8]);
        put_body(ver);
        if (ver != sb.version_reg) begin
            return;
        end
        put_body(kind);
        put_body(len);
        if (len > MAX_PAYLOAD) begin
            return;
        end
        for (int i = 0; i < len; i++) begin
            put_body(8'($urandom));
        end
        if (bad_crc) begin
            tx_crc = tx_crc ^ 16'(1 << $urandom_range(0, 15));
        end
        tx_bytes.push_back(tx_crc[7:0]);
        tx_bytes.push_back(tx_crc[15:8]);
    endtask

    // Brings the block to rest: the input goes quiet, every predicted beat
    // is collected, and a few more cycles let any parsing settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
    endtask

    task automatic program_version(input logic [7:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.version_reg = v;
        versions_used++;
        @(posedge aclk);
    endtask

    // Random traffic until about budget framed bytes have gone in. Most of
    // it is well-formed frames with random content and in-order sequence
    // numbers; the rest is noise, broken sync, wrong versions, oversized
    // lengths and corrupted CRCs.
    task automatic run_random_phase(input int budget, input bit with_hold);
        int          used;
        int          r;
        int          n;
        logic [15:0] seq;
        logic [7:0]  len;
        logic [7:0]  b;
        used = 0;
        while (used < budget) begin
            tx_pace = ($urandom_range(0, 3) != 0);
            if (with_hold && !hold_done && used >= budget / 3) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 8) begin
                // Line noise with no first sync byte in it; a hunting parser just
                // drops it, and it does not count towards the budget.
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++) begin
                    do begin
                        b = 8'($urandom);
                    end while (b == SYNC_A);
                    tx_bytes.push_back(b);
                end
                send_queued();
                continue;
            end
            n = $urandom_range(0, 99);
            if (n < 85) begin
                seq = next_seq;
            end else if (n < 95) begin
                seq = 16'($urandom);
            end else begin
                seq = next_seq + 16'd2;
            end
            n = $urandom_range(0, 99);
            if (n < 70) begin
                len = 8'($urandom_range(0, 6));
            end else if (n < 90) begin
                len = 8'($urandom_range(7, MAX_PAYLOAD - 1));
            end else begin
                len = 8'(MAX_PAYLOAD);
            end
            if (r < 13) begin
                tx_bytes.push_back(SYNC_A);
                if ($urandom_range(0, 1) != 0) begin
                    tx_bytes.push_back(SYNC_B);
                    do begin
                        b = 8'($urandom);
                    end while (b == SYNC_C);
                end else begin
                    do begin
                        b = 8'($urandom);
                    end while (b == SYNC_B);
                end
                tx_bytes.push_back(b);
            end else if (r < 18) begin
                queue_frame(seq, sb.version_reg ^ 8'($urandom_range(1, 255)),
                            8'($urandom), len, 1'b0);
            end else if (r < 22) begin
                queue_frame(seq, sb.version_reg, 8'($urandom),
                            8'($urandom_range(MAX_PAYLOAD + 1, 255)), 1'b0);
            end else if (r < 30) begin
                queue_frame(seq, sb.version_reg, 8'($urandom), len, 1'b1);
            end else begin
                queue_frame(seq, sb.version_reg, 8'($urandom), len, 1'b0);
                next_seq = seq + 16'd1;
            end
            used += tx_bytes.size();
            send_queued();
        end
    endtask

    initial begin : stimulus
        sb = new();
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'h00;
        cfg_we    <= 1'b0;
        cfg_wdata <= 8'h00;
        tx_pace   = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed opening under the reset version. A doubled first sync
        // byte leads into an empty frame numbered 0xFFFF, so that the next
        // in-order frame wraps to zero. Then a second sync byte that is
        // wrong, a third sync byte that is a first sync byte, a wrong
        // version and a length one above the maximum.
        tx_bytes.push_back(SYNC_A);
        queue_frame(16'hFFFF, VERSION_RESET, 8'h00, 8'd0, 1'b0);
        next_seq = 16'h0000;
        tx_bytes.push_back(SYNC_A);
        tx_bytes.push_back(8'h11);
        tx_bytes.push_back(SYNC_A);
        tx_bytes.push_back(SYNC_B);
        tx_bytes.push_back(SYNC_A);
        queue_frame(16'h0000, 8'h00, 8'h00, 8'd0, 1'b0);
        queue_frame(16'h1234, VERSION_RESET, 8'h5A, 8'(MAX_PAYLOAD + 1), 1'b0);
        send_queued();

        // Random traffic under the reset version, then under both extreme
        // versions and one drawn at random. The long receiver hold-off
        // falls in the second phase.
        run_random_phase(75, 1'b0);
        program_version(8'h00);
        run_random_phase(75, 1'b1);
        program_version(8'hFF);
        run_random_phase(75, 1'b0);
        program_version(8'($urandom_range(2, 254)));
        run_random_phase(75, 1'b0);

        drain();
        repeat (12) @(posedge aclk);

        $display("Run covered %0d bytes under %0d protocol versions,",
                 bytes_sent, versions_used);
        $display("giving %0d good frames, %0d error reports, %0d beats compared, %0d hold-off(s).",
                 sb.good_frames, sb.error_reports, sb.beats_checked, long_holds);
        if (sb.fails == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run, so it only fires on a hang.
    initial begin : watchdog
        #6_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/frc_pkg.sv
design/frc_ctrl.sv
design/frc_datapath.sv
design/framed_packet_receiver_crc16.sv
tb/tb_framed_packet_receiver_crc16.sv
